// File: sv/flwm_pkg.sv
package flwm_pkg;

  // Store sizes. MAX_KEEP is a power of two so that the ring of recent leaf ids
  // wraps by masking.
  localparam int MAX_OBS  = 4096;
  localparam int MAX_KEEP = 64;

  localparam int OBS_AW  = $clog2(MAX_OBS);
  localparam int CNT_W   = OBS_AW + 1;
  localparam int RING_W  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int HIT_W   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  localparam int KIND_W   = 2;
  localparam int LEAF_W   = 16;
  localparam int OBS_W    = 12;
  localparam int TAG_W    = 16;
  localparam int KEEP_W   = 7;
  localparam int WINDOW_W = 16;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // Register select is address bit 2.
  localparam logic REG_KEEP   = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  typedef struct packed {
    logic clear;
    logic capture;
    logic load_rd;
    logic load_wr;
    logic q_start;
    logic q_rd;
    logic q_skip;
    logic emit_mid;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic lc_full;
    logic scan_end;
    logic pend;
    logic cap;
    logic same;
    logic out_free;
  } stat_t;

endpackage

// File: sv/flwm_ctrl.sv
module flwm_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [flwm_pkg::KIND_W-1:0] kind,
  input  flwm_pkg::stat_t          stat,
  output flwm_pkg::cmd_t           cmd,
  output logic                     in_stall
);
  import flwm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_Q_RD,
    S_Q_CHK
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (kind)
            KIND_CLEAR: cmd.clear = 1'b1;
            KIND_LOAD: begin
              if (!stat.lc_full) begin
                state_next = S_LD_RD;
              end
            end
            KIND_QUERY: begin
              cmd.q_start = 1'b1;
              state_next  = S_Q_RD;
            end
            default: ;
          endcase
        end
      end
      S_LD_RD: begin
        cmd.load_rd = 1'b1;
        state_next  = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.load_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_Q_RD: begin
        // A held hit becomes the final word at the end of the store or at the cap.
        if (stat.pend && (stat.cap || stat.scan_end)) begin
          if (stat.out_free) begin
            cmd.emit_last = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (stat.scan_end) begin
          state_next = S_IDLE;
        end else begin
          cmd.q_rd   = 1'b1;
          state_next = S_Q_CHK;
        end
      end
      S_Q_CHK: begin
        if (stat.pend) begin
          if (stat.out_free) begin
            if (stat.same) begin
              cmd.emit_mid = 1'b1;
              state_next   = S_Q_RD;
            end else begin
              cmd.emit_last = 1'b1;
              state_next    = S_IDLE;
            end
          end
        end else begin
          cmd.q_skip = 1'b1;
          state_next = S_Q_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/flwm_dp.sv
module flwm_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  flwm_pkg::cmd_t                cmd,
  output flwm_pkg::stat_t               stat,
  input  logic [flwm_pkg::KEEP_W-1:0]   keep_per_leaf,
  input  logic [flwm_pkg::WINDOW_W-1:0] match_window,
  input  logic [flwm_pkg::LEAF_W-1:0]   leaf_id,
  input  logic [flwm_pkg::OBS_W-1:0]    obs_number,
  input  logic [flwm_pkg::TAG_W-1:0]    query_number,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [flwm_pkg::TAG_W-1:0]    query_tag,
  output logic [flwm_pkg::OBS_W-1:0]    obs_hit,
  output logic                          last_hit
);
  import flwm_pkg::*;

  logic [LEAF_W-1:0] kept_leaf [MAX_OBS];
  logic [OBS_W-1:0]  kept_obs  [MAX_OBS];
  logic [LEAF_W-1:0] recent_leaves [MAX_KEEP];

  logic [LEAF_W-1:0] item_leaf;
  logic [OBS_W-1:0]  item_obs;
  logic [TAG_W-1:0]  item_tag;

  logic [CNT_W-1:0]  loaded_count;
  logic [CNT_W-1:0]  kept_count;
  logic [CNT_W-1:0]  scan_idx;
  logic [HIT_W-1:0]  emitted;

  logic [LEAF_W-1:0] recent_rd;
  logic [LEAF_W-1:0] rd_leaf;
  logic [OBS_W-1:0]  rd_obs;

  logic              pend_vld;
  logic [LEAF_W-1:0] pend_leaf;
  logic [OBS_W-1:0]  pend_obs;

  logic [KEEP_W-1:0] keep_eff;
  logic [RING_W-1:0] ring_rd_addr;
  logic              keep_it;
  logic              write_kept;
  logic [LEAF_W-1:0] diff;
  logic              in_window;
  logic              out_free;

  assign keep_eff     = (keep_per_leaf > KEEP_W'(MAX_KEEP)) ? KEEP_W'(MAX_KEEP) : keep_per_leaf;
  assign ring_rd_addr = loaded_count[RING_W-1:0] - keep_eff[RING_W-1:0];

  always_comb begin
    if (keep_eff == '0) begin
      keep_it = 1'b0;
    end else if (loaded_count < CNT_W'(keep_eff)) begin
      keep_it = 1'b1;
    end else begin
      keep_it = (recent_rd != item_leaf);
    end
  end

  assign write_kept = cmd.load_wr && keep_it && (kept_count < CNT_W'(MAX_OBS));

  assign diff      = (rd_leaf >= item_leaf) ? (rd_leaf - item_leaf) : (item_leaf - rd_leaf);
  assign in_window = (diff <= match_window);
  assign out_free  = !out_valid || !out_stall;

  assign stat.lc_full  = (loaded_count >= CNT_W'(MAX_OBS));
  assign stat.scan_end = (scan_idx == kept_count);
  assign stat.pend     = pend_vld;
  assign stat.cap      = (emitted == HIT_W'(MAX_KEEP - 1));
  assign stat.same     = (rd_leaf == pend_leaf);
  assign stat.out_free = out_free;

  // Ring of recent leaf ids: read in S_LD_RD, then write over the oldest slot in S_LD_WR.
  always_ff @(posedge clk) begin
    if (cmd.load_rd) begin
      recent_rd <= recent_leaves[ring_rd_addr];
    end
    if (cmd.load_wr) begin
      recent_leaves[loaded_count[RING_W-1:0]] <= item_leaf;
    end
  end

  // Leaf store, one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (write_kept) begin
      kept_leaf[kept_count[OBS_AW-1:0]] <= item_leaf;
      kept_obs[kept_count[OBS_AW-1:0]]  <= item_obs;
    end
    if (cmd.q_rd) begin
      rd_leaf <= kept_leaf[scan_idx[OBS_AW-1:0]];
      rd_obs  <= kept_obs[scan_idx[OBS_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_leaf <= leaf_id;
      item_obs  <= obs_number;
      item_tag  <= query_number;
    end
    if (cmd.q_skip && in_window) begin
      pend_leaf <= rd_leaf;
      pend_obs  <= rd_obs;
    end
    if (cmd.emit_mid) begin
      pend_leaf <= rd_leaf;
      pend_obs  <= rd_obs;
    end
    if (cmd.emit_mid || cmd.emit_last) begin
      query_tag <= item_tag;
      obs_hit   <= pend_obs;
      last_hit  <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      kept_count   <= '0;
      scan_idx     <= '0;
      emitted      <= '0;
      pend_vld     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.clear) begin
        loaded_count <= '0;
        kept_count   <= '0;
      end
      if (cmd.load_wr) begin
        loaded_count <= loaded_count + CNT_W'(1);
      end
      if (write_kept) begin
        kept_count <= kept_count + CNT_W'(1);
      end

      if (cmd.q_start) begin
        scan_idx <= '0;
        emitted  <= '0;
        pend_vld <= 1'b0;
      end
      if (cmd.q_skip) begin
        scan_idx <= scan_idx + CNT_W'(1);
        if (in_window) begin
          pend_vld <= 1'b1;
        end
      end
      if (cmd.emit_mid) begin
        scan_idx <= scan_idx + CNT_W'(1);
        emitted  <= emitted + HIT_W'(1);
      end
      if (cmd.emit_last) begin
        pend_vld <= 1'b0;
      end

      if (cmd.emit_mid || cmd.emit_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/forest_leaf_weight_matcher_unit.sv
// Channel   Direction  Handshake            Word
// input     in         in_valid / in_stall  kind, leaf_id, obs_number, query_number
// result    out        out_valid / out_stall query_tag, obs_hit, last_hit
// config    in         APB write/read       keep_per_leaf (0x0), match_window (0x4)
//
// A clear is handled in the idle state; a load passes a ring read, then a store write.
// A query reads kept entries through the single registered read port, each in a read
// state and then a check state, up to the entry after its first matching run, and
// ends in the read state when the scan reaches the end of the store or the result cap.
// A stalled result word holds the query. Reset is synchronous and empties the store
// and the load count; registers return to keep_per_leaf 1 and match_window 0.
module forest_leaf_weight_matcher_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [flwm_pkg::KIND_W-1:0]   kind,
  input  logic [flwm_pkg::LEAF_W-1:0]   leaf_id,
  input  logic [flwm_pkg::OBS_W-1:0]    obs_number,
  input  logic [flwm_pkg::TAG_W-1:0]    query_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [flwm_pkg::TAG_W-1:0]    query_tag,
  output logic [flwm_pkg::OBS_W-1:0]    obs_hit,
  output logic                          last_hit,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [flwm_pkg::PADDR_W-1:0]  paddr,
  input  logic [flwm_pkg::PDATA_W-1:0]  pwdata,
  output logic [flwm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import flwm_pkg::*;

  logic [KEEP_W-1:0]   keep_per_leaf;
  logic [WINDOW_W-1:0] match_window;
  cmd_t                cmd;
  stat_t               stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_per_leaf <= KEEP_W'(1);
      match_window  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_KEEP:   keep_per_leaf <= pwdata[KEEP_W-1:0];
        REG_WINDOW: match_window  <= pwdata[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_KEEP:   prdata = PDATA_W'(keep_per_leaf);
      REG_WINDOW: prdata = PDATA_W'(match_window);
      default:    prdata = '0;
    endcase
  end

  flwm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  flwm_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .keep_per_leaf (keep_per_leaf),
    .match_window  (match_window),
    .leaf_id       (leaf_id),
    .obs_number    (obs_number),
    .query_number  (query_number),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .query_tag     (query_tag),
    .obs_hit       (obs_hit),
    .last_hit      (last_hit)
  );

endmodule

// File: sv/flwm_checker.sv
module flwm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [flwm_pkg::KIND_W-1:0]   kind,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [flwm_pkg::TAG_W-1:0]    query_tag,
  input logic [flwm_pkg::OBS_W-1:0]    obs_hit,
  input logic                          last_hit
);
  import flwm_pkg::*;

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(query_tag) && $stable(obs_hit)
      && $stable(last_hit))
    else $error("result word changed while stalled");

  // While a query has words still to come, no new item is taken.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_hit |-> in_stall)
    else $error("input taken in the middle of a query");

  // Clears and loads never produce a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind != KIND_QUERY && !out_valid |=> !out_valid)
    else $error("result appeared after a non-query item");

  // After reset the block is empty and ready.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind forest_leaf_weight_matcher_unit flwm_checker u_flwm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .kind      (kind),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .query_tag (query_tag),
  .obs_hit   (obs_hit),
  .last_hit  (last_hit)
);
